>>> rtl/stlbs_pkg.sv
package stlbs_pkg;

    localparam int unsigned DEPTH_DEFAULT = 256;

    // action codes of an input item
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // status codes of a result item
    localparam logic [1:0] STATUS_APPENDED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_SEARCHED = 2'd2;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       linear_found;
        logic       binary_found;
        logic [7:0] binary_index;
        logic [8:0] entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_BPROBE,
        ST_BCMP,
        ST_FINISH
    } state_t;

    // sequencer to range tracker
    typedef struct packed {
        logic start;
        logic step;
    } bs_ctrl_t;

    // range tracker to sequencer
    typedef struct packed {
        logic range_empty;
        logic key_equal;
        logic key_less;
    } bs_stat_t;

endpackage

>>> rtl/stlbs_if.sv
interface stlbs_req_if;
    logic             valid;
    logic             ready;
    stlbs_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stlbs_rsp_if;
    logic             valid;
    logic             ready;
    stlbs_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/stlbs_bsearch.sv
module stlbs_bsearch #(
    parameter int unsigned DEPTH = stlbs_pkg::DEPTH_DEFAULT,
    localparam int unsigned CW = $clog2(DEPTH + 1),
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stlbs_pkg::bs_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic signed [31:0]  key,
    input  logic signed [31:0]  rdata,
    output logic [AW-1:0]       probe,
    output stlbs_pkg::bs_stat_t stat
);
    import stlbs_pkg::*;

    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] half_span;
    logic [CW-1:0] probe_wide;

    // probe = lo + (hi - lo - 1) / 2, only meaningful while lo < hi
    assign half_span  = (hi_reg - lo_reg - CW'(1)) >> 1;
    assign probe_wide = lo_reg + half_span;
    assign probe      = probe_wide[AW-1:0];

    assign stat.range_empty = !(lo_reg < hi_reg);
    assign stat.key_equal   = (rdata == key);
    assign stat.key_less    = (rdata < key);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = count;
        end
        else if (ctrl.step)
        begin
            if (stat.key_less)
                lo_next = probe_wide + CW'(1);
            else
                hi_next = probe_wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

endmodule

>>> rtl/sorted_table_linear_binary_search.sv
// sorted table with linear and binary search
//
// req (sink): one item per handshake; action 0 appends value at the table
//   end, action 1 searches the table for value. ready is high only while
//   the sequencer is idle, so one item is worked on at a time.
// rsp (source): one result item per request item, in order, held in an
//   output register. the next request is taken while a result still waits.
//
// sequence: an append goes from idle to finish, which loads its result. a
//   search first scans linearly (one table read per cycle through the
//   single read port of the table memory, stopping at the first equal
//   entry), then does binary probes (read, then compare and narrow), at
//   most ceil(log2(count + 1)) probes, then finishes.
// reset: the fill count clears, table contents stay undefined; no clearing
//   pass is needed since only entries below the fill count are ever read.
// stall: a finished result waits in the output register while rsp.ready is
//   low; the sequencer holds its finished item until the register frees.
module sorted_table_linear_binary_search #(
    parameter int unsigned DEPTH = stlbs_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    stlbs_req_if.sink  req,
    stlbs_rsp_if.source rsp
);
    import stlbs_pkg::*;

    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNW = CW + 9;
    localparam int unsigned IXW = AW + 8;

    // table memory: one write port for appends, one registered read port
    logic signed [31:0] stored_values [DEPTH];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic signed [31:0] key_reg, key_next;
    logic [1:0]         status_reg, status_next;
    logic               lin_found_reg, lin_found_next;
    logic               bin_found_reg, bin_found_next;
    logic [AW-1:0]      bin_idx_reg, bin_idx_next;

    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;
    logic               out_load;

    bs_ctrl_t           bs_ctrl;
    bs_stat_t           bs_stat;
    logic [AW-1:0]      probe;

    logic               accept;
    logic               match_now;
    logic               issue;
    logic [CNW-1:0]     count_wide;
    logic [IXW-1:0]     idx_wide;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // a read issued last cycle has its data in rdata_reg now
    assign match_now = (state_reg == ST_LSCAN) && pend_reg && bs_stat.key_equal;
    assign issue     = (state_reg == ST_LSCAN) && (scan_idx_reg < count_reg)
                       && !lin_found_reg && !match_now;

    // scan address during the linear pass, probe address otherwise
    assign rd_addr = (state_reg == ST_LSCAN) ? scan_idx_reg[AW-1:0] : probe;

    assign count_wide = CNW'(count_reg);
    assign idx_wide   = IXW'(bin_idx_reg);

    stlbs_bsearch #(
        .DEPTH (DEPTH)
    ) u_bsearch (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (bs_ctrl),
        .count (count_reg),
        .key   (key_reg),
        .rdata (rdata_reg),
        .probe (probe),
        .stat  (bs_stat)
    );

    // writes happen only when idle and read data is used only during a search,
    // so a read that is used never meets a write to the same entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stored_values[count_reg[AW-1:0]] <= req.data.value;
        rdata_reg <= stored_values[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req.data.action == ACT_SEARCH) ? ST_LSCAN : ST_FINISH;
            end
            ST_LSCAN:
            begin
                if (!issue && !pend_reg)
                    state_next = ST_BPROBE;
            end
            ST_BPROBE:
            begin
                state_next = bs_stat.range_empty ? ST_FINISH : ST_BCMP;
            end
            ST_BCMP:
            begin
                state_next = bs_stat.key_equal ? ST_FINISH : ST_BPROBE;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls and next values
    always_comb
    begin
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        key_next       = key_reg;
        status_next    = status_reg;
        lin_found_next = lin_found_reg;
        bin_found_next = bin_found_reg;
        bin_idx_next   = bin_idx_reg;
        wr_en          = 1'b0;
        bs_ctrl        = '0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next       = req.data.value;
                    scan_idx_next  = '0;
                    lin_found_next = 1'b0;
                    bin_found_next = 1'b0;
                    bin_idx_next   = '0;
                    if (req.data.action == ACT_SEARCH)
                    begin
                        status_next   = STATUS_SEARCHED;
                        bs_ctrl.start = 1'b1;
                    end
                    else if (count_reg < CW'(DEPTH))
                    begin
                        status_next = STATUS_APPENDED;
                        wr_en       = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
            end
            ST_LSCAN:
            begin
                pend_next = issue;
                if (issue)
                    scan_idx_next = scan_idx_reg + CW'(1);
                if (match_now)
                    lin_found_next = 1'b1;
            end
            ST_BPROBE:
            begin
                // read of the probed entry is issued through rd_addr
            end
            ST_BCMP:
            begin
                if (bs_stat.key_equal)
                begin
                    bin_found_next = 1'b1;
                    bin_idx_next   = probe;
                end
                else
                begin
                    bs_ctrl.step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_data_next = out_data_reg;
        if (out_load)
        begin
            out_data_next.status       = status_reg;
            out_data_next.linear_found = lin_found_reg;
            out_data_next.binary_found = bin_found_reg;
            out_data_next.binary_index = idx_wide[7:0];
            out_data_next.entry_count  = count_wide[8:0];
        end
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        key_reg       <= key_next;
        status_reg    <= status_next;
        lin_found_reg <= lin_found_next;
        bin_found_reg <= bin_found_next;
        bin_idx_reg   <= bin_idx_next;
        out_data_reg  <= out_data_next;
    end

    // a binary hit is an entry below the fill count, so the scan saw it too
    a_bin_implies_lin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.binary_found || out_data_reg.linear_found))
        else $error("binary hit without linear hit");

    // the fill count moves only on an accepted append to a table with room
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && (req.data.action == ACT_APPEND)) |=> (count_reg == $past(count_reg)))
        else $error("fill count changed without an append");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.data.action == ACT_APPEND) && (count_reg < CW'(DEPTH)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append to a table with room did not grow it");

    // every compare follows the cycle that issued its probe read
    a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BCMP) |-> ($past(state_reg) == ST_BPROBE))
        else $error("compare without a probe read");

    // a new result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule
